/* hw/rtl/mlf_pkg.sv */
package mlf_pkg;

    // Field widths of the frame header and of the forwarding result.
    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int HOP_W  = 8;
    localparam int MASK_W = 16;
    localparam int PIU_W  = 5;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_PORTS_IN_USE = 1'b0;
    localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

    localparam logic [HOP_W-1:0] HOP_MAX = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new header and clear the search results
        logic scan;    // read the table entry at the scan index and advance it
        logic learn;   // update or add the source entry
        logic finish;  // build the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic table_empty;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/mlf_ctrl.sv */
module mlf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mlf_pkg::sts_t sts,
    output mlf_pkg::cmd_t cmd
);
    import mlf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_LEARN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.table_empty ? ST_LEARN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // The last entry read is compared in this cycle.
            ST_DRAIN: begin
                state_next = ST_LEARN;
            end
            ST_LEARN: begin
                cmd.learn  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/mlf_datapath.sv */
module mlf_datapath #(
    parameter int TABLE_ENTRIES = 64,
    parameter int NUM_PORTS     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlf_pkg::cmd_t                 cmd,
    output mlf_pkg::sts_t                 sts,
    input  logic [mlf_pkg::MAC_W-1:0]     src_mac,
    input  logic [mlf_pkg::MAC_W-1:0]     dst_mac,
    input  logic [mlf_pkg::PORT_W-1:0]    arrival_port,
    input  logic [mlf_pkg::HOP_W-1:0]     hop_count,
    input  logic [mlf_pkg::PIU_W-1:0]     ports_in_use,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [mlf_pkg::MASK_W-1:0]    egress_mask,
    output logic                          flooded,
    output logic [mlf_pkg::HOP_W-1:0]     hop_count_out,
    output logic                          learned_new,
    output logic                          table_full
);
    import mlf_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = MAC_W + PORT_W;
    localparam int NP_W  = $clog2(NUM_PORTS + 1) + 1;
    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);
    localparam logic [NP_W-1:0]  NPORTS_C  = NP_W'(NUM_PORTS);

    // Table memory: {mac, port} per slot. Slots fill from zero upward and are
    // never freed, so the fill count alone tells which slots are valid.
    logic [ENT_W-1:0] mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic [MAC_W-1:0]  src_reg, dst_reg;
    logic [PORT_W-1:0] arr_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              src_hit_reg, src_hit_next;
    logic [IDX_W-1:0]  src_slot_reg, src_slot_next;
    logic              dst_hit_reg, dst_hit_next;
    logic [PORT_W-1:0] dst_port_reg, dst_port_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              lrn_reg, lrn_next;
    logic              full_reg, full_next;

    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_flood_reg;
    logic [HOP_W-1:0]  out_hop_reg;
    logic              out_lrn_reg;
    logic              out_full_reg;

    logic [MAC_W-1:0]  rd_mac;
    logic [PORT_W-1:0] rd_port;
    logic [NP_W-1:0]   piu_ext;
    logic [NP_W-1:0]   n_ports;
    logic [MASK_W-1:0] flood_mask;
    logic              fwd_onehot;

    assign rd_mac  = rd_data_reg[ENT_W-1:PORT_W];
    assign rd_port = rd_data_reg[PORT_W-1:0];

    assign sts.table_empty = (count_reg == '0);
    assign sts.scan_last   = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign sts.out_free    = !out_valid_reg || res_ready;

    // Search, learning and fill count.
    always_comb begin
        idx_next      = idx_reg;
        cmp_vld_next  = cmd.scan;
        src_hit_next  = src_hit_reg;
        src_slot_next = src_slot_reg;
        dst_hit_next  = dst_hit_reg;
        dst_port_next = dst_port_reg;
        count_next    = count_reg;
        lrn_next      = lrn_reg;
        full_next     = full_reg;
        mem_we        = 1'b0;
        mem_waddr     = src_slot_reg;

        if (cmd.load) begin
            idx_next     = '0;
            src_hit_next = 1'b0;
            dst_hit_next = 1'b0;
            lrn_next     = 1'b0;
            full_next    = 1'b0;
        end
        if (cmd.scan) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmp_vld_reg) begin
            if (rd_mac == src_reg) begin
                src_hit_next  = 1'b1;
                src_slot_next = cmp_idx_reg;
            end
            if (rd_mac == dst_reg) begin
                dst_hit_next  = 1'b1;
                dst_port_next = rd_port;
            end
        end
        if (cmd.learn) begin
            if (src_hit_reg) begin
                mem_we = 1'b1;
            end else if (count_reg < ENTRIES_C) begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[IDX_W-1:0];
                count_next = count_reg + CNT_W'(1);
                lrn_next   = 1'b1;
            end else begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {src_reg, arr_reg};
        end
        rd_data_reg <= mem[idx_reg];
    end

    // Flood mask: connected ports, clamped to the port count, minus arrival.
    assign piu_ext = NP_W'(ports_in_use);
    assign n_ports = (piu_ext > NPORTS_C) ? NPORTS_C : piu_ext;

    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            flood_mask[j] = (NP_W'(j) < n_ports) && (PORT_W'(j) != arr_reg);
        end
    end

    // A destination equal to the source always resolves to the arrival port
    // after learning, so it floods; other entries are untouched by learning.
    assign fwd_onehot = dst_hit_reg && (dst_reg != src_reg) && (dst_port_reg != arr_reg);

    assign out_valid_next = cmd.finish || (out_valid_reg && !res_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            src_reg <= src_mac;
            dst_reg <= dst_mac;
            arr_reg <= arrival_port;
            hop_reg <= hop_count;
        end
        idx_reg      <= idx_next;
        cmp_idx_reg  <= idx_reg;
        src_hit_reg  <= src_hit_next;
        src_slot_reg <= src_slot_next;
        dst_hit_reg  <= dst_hit_next;
        dst_port_reg <= dst_port_next;
        lrn_reg      <= lrn_next;
        full_reg     <= full_next;
        if (cmd.finish) begin
            out_mask_reg  <= fwd_onehot ? (MASK_W'(1) << dst_port_reg) : flood_mask;
            out_flood_reg <= !fwd_onehot;
            out_hop_reg   <= (hop_reg == HOP_MAX) ? HOP_MAX : hop_reg + HOP_W'(1);
            out_lrn_reg   <= lrn_reg;
            out_full_reg  <= full_reg;
        end
    end

    assign res_valid     = out_valid_reg;
    assign egress_mask   = out_mask_reg;
    assign flooded       = out_flood_reg;
    assign hop_count_out = out_hop_reg;
    assign learned_new   = out_lrn_reg;
    assign table_full    = out_full_reg;

endmodule

/* hw/rtl/mac_learning_forwarder.sv */
// Each header goes through the controller states idle (load), scan over the N addresses in
// the table, drain, learn and finish, which waits for a free output register; scan and drain
// are skipped with an empty table. A new header is taken only in idle, once the last has
// finished; the scan reads one table entry per cycle through the single memory read port.
// Reset (aresetn, synchronous, active low) empties the table and sets ports_in_use to 16.
module mac_learning_forwarder #(
    parameter int TABLE_ENTRIES = 64,
    parameter int NUM_PORTS     = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Header input.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [47:0] src_mac, [95:48] dst_mac, [99:96] arrival_port,
    // [107:100] hop_count, [111:108] zero
    input  logic [mlf_pkg::S_TDATA_W-1:0]     s_tdata,
    // Forwarding result.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] egress_mask, [16] flooded, [24:17] hop_count_out,
    // [25] learned_new, [26] table_full, [31:27] zero
    output logic [mlf_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mlf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mlf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mlf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mlf_pkg::*;

    // The block is split into a small controller and a datapath. For each header
    // the controller walks the table once; the datapath compares every stored
    // address against both the source and the destination in the same pass. A
    // new source goes into the first free slot, which is always the fill count,
    // because entries are never removed. The result sits in an output register,
    // so the next header transfer can be taken while the result waits.

    logic [PIU_W-1:0] piu_reg, piu_next;
    logic             cfg_wr;
    logic [0:0]       reg_index;

    cmd_t cmd;
    sts_t sts;

    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic [HOP_W-1:0]  hop_count_out;
    logic              learned_new;
    logic              table_full;

    // Register file: a single register, ports_in_use, at byte address zero.
    assign pready    = 1'b1;
    assign reg_index = paddr[2:2];
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_comb begin
        piu_next = piu_reg;
        if (cfg_wr && (reg_index == REG_PORTS_IN_USE)) begin
            piu_next = pwdata[PIU_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piu_reg <= PIU_RESET;
        end else begin
            piu_reg <= piu_next;
        end
    end

    assign prdata = (reg_index == REG_PORTS_IN_USE) ? APB_DATA_W'(piu_reg) : '0;

    mlf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mlf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_PORTS     (NUM_PORTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .src_mac       (s_tdata[47:0]),
        .dst_mac       (s_tdata[95:48]),
        .arrival_port  (s_tdata[99:96]),
        .hop_count     (s_tdata[107:100]),
        .ports_in_use  (piu_reg),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .egress_mask   (egress_mask),
        .flooded       (flooded),
        .hop_count_out (hop_count_out),
        .learned_new   (learned_new),
        .table_full    (table_full)
    );

    assign m_tdata = {5'd0, table_full, learned_new, hop_count_out, flooded, egress_mask};

endmodule
